>>> design/qks_pkg.sv
package qks_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_FRAME_RATE    = 2'd0;
  localparam logic [1:0] CFG_CLIP_DURATION = 2'd1;
  localparam logic [1:0] CFG_FRAME_COUNT   = 2'd2;

  // Item modes.
  localparam logic [1:0] MODE_LOCATE    = 2'd0;
  localparam logic [1:0] MODE_ROTATION  = 2'd1;
  localparam logic [1:0] MODE_TRANSLATE = 2'd2;
  localparam logic [1:0] MODE_SCALE     = 2'd3;

  // Number of pose tracks; the slot field is sized for exactly this many.
  localparam int unsigned MAX_TRACKS = 1024;

  localparam logic [31:0] RATE_RESET  = 32'd1966080;
  localparam logic [33:0] ROT_MID     = 34'd2147450880;
  localparam logic [63:0] LEN2_FLOOR  = 64'd4611546;
  localparam logic [16:0] BLEND_ONE   = 17'd65536;
  localparam logic [64:0] ROUND_HALF  = 65'd8388608;

  localparam int unsigned IN_DATA_W  = 240;
  localparam int unsigned OUT_DATA_W = 176;
  localparam int unsigned OUT_USER_W = 3;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 17;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         slot;
    logic [15:0]        k;
    logic [16:0]        a;
    logic               anim;
    logic [1:0]         idx;
    logic signed [31:0] val0;
    logic               tiny_len;
  } meta_t;

endpackage

>>> design/quantized_keyframe_sampler.sv
// Channel    Direction  Handshake                 Payload
// in_        slave      in_tvalid / in_tready     in_tdata, in_tuser (mode)
// out_       master     out_tvalid / out_tready   out_tdata, out_tuser (kind, animated)
// cfg_       slave      cfg_valid / cfg_ready     cfg_addr, cfg_data
//
// One beat is accepted every cycle while the output is not stalled. Most of the depth is
// the 32 stages of the square root and the 17 stages of the quotient, one bit per stage.
// rst_n is synchronous; it clears the valid bits, duration and count, and presets the rate.
// A stall on the output freezes the whole pipeline in place, so nothing is lost or repeated.
module quantized_keyframe_sampler
  import qks_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] time_req, [41:32] slot, [43:42] component, [107:44] key_first,
  // [171:108] key_next, [203:172] range_min, [235:204] range_step, zero fill above
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [9:0] slot_out, [25:10] frame_index, [42:26] blend, [74:43] value_x,
  // [106:75] value_y, [138:107] value_z, [170:139] value_w, zero fill above
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // [1:0] kind, [2] animated
  output logic [OUT_USER_W-1:0]  out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_addr,
  input  logic [31:0]            cfg_data
);

  logic [31:0] frame_rate_r, clip_duration_r;
  logic [15:0] frame_count_r;
  logic        adv;
  logic        out_valid_r;

  // The whole pipeline moves as one when the output register is free or being drained.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rate_r    <= RATE_RESET;
      clip_duration_r <= '0;
      frame_count_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_FRAME_RATE:    frame_rate_r    <= cfg_data;
        CFG_CLIP_DURATION: clip_duration_r <= cfg_data;
        CFG_FRAME_COUNT:   frame_count_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage 1: unpack and clamp the time to the clip length.
  logic               v1_r;
  meta_t              m1_r, m1_nxt;
  logic [31:0]        t1_r, t_in;
  logic [63:0]        k0_1_r, k1_1_r;
  logic signed [31:0] rmin1_r;
  logic [31:0]        step1_r;

  always_comb begin
    t_in          = in_tdata[31:0];
    m1_nxt        = '0;
    m1_nxt.kind   = in_tuser;
    m1_nxt.slot   = 10'(32'(in_tdata[41:32]) % MAX_TRACKS);
    m1_nxt.anim   = (frame_count_r >= 16'd2);
    m1_nxt.idx    = (in_tuser == MODE_TRANSLATE) ? in_tdata[43:42] : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
    if (adv) begin
      m1_r    <= m1_nxt;
      t1_r    <= (t_in > clip_duration_r) ? clip_duration_r : t_in;
      k0_1_r  <= in_tdata[107:44];
      k1_1_r  <= in_tdata[171:108];
      rmin1_r <= $signed(in_tdata[203:172]);
      step1_r <= in_tdata[235:204];
    end
  end

  // Stage 2: time times rate, exact in Q32.32.
  logic               v2_r;
  meta_t              m2_r;
  logic [63:0]        x2_r, k0_2_r, k1_2_r;
  logic signed [31:0] rmin2_r;
  logic [31:0]        step2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      m2_r    <= m1_r;
      x2_r    <= 64'(t1_r) * 64'(frame_rate_r);
      k0_2_r  <= k0_1_r;
      k1_2_r  <= k1_1_r;
      rmin2_r <= rmin1_r;
      step2_r <= step1_r;
    end
  end

  // Stage 3: frame index and blend factor.
  logic               v3_r;
  meta_t              m3_r, m3_nxt;
  logic [63:0]        k0_3_r, k1_3_r;
  logic signed [31:0] rmin3_r;
  logic [31:0]        step3_r;
  logic [15:0]        cap;

  always_comb begin
    cap    = frame_count_r - 16'd2;
    m3_nxt = m2_r;
    if (!m2_r.anim) begin
      m3_nxt.k = '0;
      m3_nxt.a = '0;
    end else if (x2_r[63:32] > 32'(cap)) begin
      m3_nxt.k = cap;
      m3_nxt.a = BLEND_ONE;
    end else begin
      m3_nxt.k = x2_r[47:32];
      m3_nxt.a = {1'b0, x2_r[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      m3_r    <= m3_nxt;
      k0_3_r  <= k0_2_r;
      k1_3_r  <= k1_2_r;
      rmin3_r <= rmin2_r;
      step3_r <= step2_r;
    end
  end

  // Stage 4: key difference times blend, one lane per packed 16-bit code.
  logic               v4_r;
  meta_t              m4_r;
  logic [3:0][15:0]   f0_4_r;
  logic signed [34:0] prod4_r [4];
  logic signed [31:0] rmin4_r;
  logic [31:0]        step4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      m4_r    <= m3_r;
      rmin4_r <= rmin3_r;
      step4_r <= step3_r;
      for (int j = 0; j < 4; j++) begin
        f0_4_r[j]  <= k0_3_r[16*j +: 16];
        prod4_r[j] <= ($signed({1'b0, k1_3_r[16*j +: 16]}) -
                       $signed({1'b0, k0_3_r[16*j +: 16]})) * $signed({1'b0, m3_r.a});
      end
    end
  end

  // Stage 5: lerped codes, Q16.16 in code units, never negative.
  logic               v5_r;
  meta_t              m5_r;
  logic [3:0][31:0]   l5_r;
  logic signed [31:0] rmin5_r;
  logic [31:0]        step5_r;
  logic signed [34:0] lsum [4];

  always_comb begin
    for (int j = 0; j < 4; j++)
      lsum[j] = $signed({3'b0, f0_4_r[j], 16'b0}) + prod4_r[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) begin
      m5_r    <= m4_r;
      rmin5_r <= rmin4_r;
      step5_r <= step4_r;
      for (int j = 0; j < 4; j++) l5_r[j] <= lsum[j][31:0];
    end
  end

  // Stage 6: centered rotation components; translation and scale product.
  logic               v6_r;
  meta_t              m6_r;
  logic [3:0][31:0]   mabs6_r;
  logic [3:0]         mneg6_r;
  logic [63:0]        tprod6_r;
  logic signed [31:0] rmin6_r;
  logic signed [33:0] mc [4];

  always_comb begin
    for (int j = 0; j < 4; j++)
      mc[j] = $signed({2'b0, l5_r[j]}) - $signed(ROT_MID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
    if (adv) begin
      m6_r     <= m5_r;
      rmin6_r  <= rmin5_r;
      tprod6_r <= 64'(l5_r[m5_r.idx]) * 64'(step5_r);
      for (int j = 0; j < 4; j++) begin
        mneg6_r[j] <= mc[j][33];
        mabs6_r[j] <= mc[j][33] ? 32'(-mc[j]) : mc[j][31:0];
      end
    end
  end

  // Stage 7: squares of the components; rounded and saturated translation or scale value.
  logic               v7_r;
  meta_t              m7_r, m7_nxt;
  logic [3:0][31:0]   mabs7_r;
  logic [3:0]         mneg7_r;
  logic [3:0][63:0]   sq7_r;
  logic [64:0]        tround;
  logic signed [42:0] tsum;

  always_comb begin
    tround = {1'b0, tprod6_r} + ROUND_HALF;
    tsum   = 43'(rmin6_r) + $signed({2'b0, tround[64:24]});
    m7_nxt = m6_r;
    if (tsum > 43'sd2147483647)       m7_nxt.val0 = 32'sh7fffffff;
    else if (tsum < -43'sd2147483648) m7_nxt.val0 = 32'sh80000000;
    else                              m7_nxt.val0 = tsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= v6_r;
    if (adv) begin
      m7_r    <= m7_nxt;
      mabs7_r <= mabs6_r;
      mneg7_r <= mneg6_r;
      for (int j = 0; j < 4; j++) sq7_r[j] <= 64'(mabs6_r[j]) * 64'(mabs6_r[j]);
    end
  end

  // Stage 8: pair sums of the squares.
  logic             v8_r;
  meta_t            m8_r;
  logic [3:0][31:0] mabs8_r;
  logic [3:0]       mneg8_r;
  logic [63:0]      s01_8_r, s23_8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (adv) v8_r <= v7_r;
    if (adv) begin
      m8_r    <= m7_r;
      mabs8_r <= mabs7_r;
      mneg8_r <= mneg7_r;
      s01_8_r <= sq7_r[0] + sq7_r[1];
      s23_8_r <= sq7_r[2] + sq7_r[3];
    end
  end

  // Square root, one result bit per stage. Entry 0 holds the full sum of squares.
  logic             sq_vld_r [0:SQRT_STEPS];
  meta_t            sq_meta_r [0:SQRT_STEPS];
  logic [3:0][31:0] sq_mabs_r [0:SQRT_STEPS];
  logic [3:0]       sq_mneg_r [0:SQRT_STEPS];
  logic [63:0]      sq_v_r [0:SQRT_STEPS];
  logic [63:0]      sq_root_r [0:SQRT_STEPS];
  logic [63:0]      ssum;
  meta_t            m9_nxt;

  always_comb begin
    ssum            = s01_8_r + s23_8_r;
    m9_nxt          = m8_r;
    m9_nxt.tiny_len = (ssum < LEN2_FLOOR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else if (adv) sq_vld_r[0] <= v8_r;
    if (adv) begin
      sq_meta_r[0] <= m9_nxt;
      sq_mabs_r[0] <= mabs8_r;
      sq_mneg_r[0] <= mneg8_r;
      sq_v_r[0]    <= ssum;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial, v_nxt, root_nxt;

    always_comb begin
      trial = sq_root_r[i] + BIT;
      if (sq_v_r[i] >= trial) begin
        v_nxt    = sq_v_r[i] - trial;
        root_nxt = (sq_root_r[i] >> 1) + BIT;
      end else begin
        v_nxt    = sq_v_r[i];
        root_nxt = sq_root_r[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[i+1] <= 1'b0;
      else if (adv) sq_vld_r[i+1] <= sq_vld_r[i];
      if (adv) begin
        sq_meta_r[i+1] <= sq_meta_r[i];
        sq_mabs_r[i+1] <= sq_mabs_r[i];
        sq_mneg_r[i+1] <= sq_mneg_r[i];
        sq_v_r[i+1]    <= v_nxt;
        sq_root_r[i+1] <= root_nxt;
      end
    end
  end

  // Quotient of each component over the length, rounded, one quotient bit per stage.
  logic             dv_vld_r [0:DIV_STEPS];
  meta_t            dv_meta_r [0:DIV_STEPS];
  logic [3:0]       dv_mneg_r [0:DIV_STEPS];
  logic [31:0]      dv_den_r [0:DIV_STEPS];
  logic [3:0][48:0] dv_num_r [0:DIV_STEPS];
  logic [3:0][31:0] dv_rem_r [0:DIV_STEPS];
  logic [3:0][16:0] dv_quo_r [0:DIV_STEPS];
  logic [31:0]      root;
  logic [3:0][48:0] num0;

  always_comb begin
    root = sq_root_r[SQRT_STEPS][31:0];
    for (int j = 0; j < 4; j++)
      num0[j] = {1'b0, sq_mabs_r[SQRT_STEPS][j], 16'b0} + 49'(root >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (adv) dv_vld_r[0] <= sq_vld_r[SQRT_STEPS];
    if (adv) begin
      dv_meta_r[0] <= sq_meta_r[SQRT_STEPS];
      dv_mneg_r[0] <= sq_mneg_r[SQRT_STEPS];
      dv_den_r[0]  <= root;
      dv_num_r[0]  <= num0;
      dv_quo_r[0]  <= '0;
      for (int j = 0; j < 4; j++) dv_rem_r[0][j] <= num0[j][48:17];
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int unsigned B = DIV_STEPS - 1 - i;
    logic [3:0][31:0] rem_nxt;
    logic [3:0][16:0] quo_nxt;
    logic [32:0]      part [4];

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        part[j]    = {dv_rem_r[i][j], dv_num_r[i][j][B]};
        quo_nxt[j] = dv_quo_r[i][j];
        if (part[j] >= {1'b0, dv_den_r[i]}) begin
          rem_nxt[j]    = 32'(part[j] - {1'b0, dv_den_r[i]});
          quo_nxt[j][B] = 1'b1;
        end else begin
          rem_nxt[j] = part[j][31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[i+1] <= 1'b0;
      else if (adv) dv_vld_r[i+1] <= dv_vld_r[i];
      if (adv) begin
        dv_meta_r[i+1] <= dv_meta_r[i];
        dv_mneg_r[i+1] <= dv_mneg_r[i];
        dv_den_r[i+1]  <= dv_den_r[i];
        dv_num_r[i+1]  <= dv_num_r[i];
        dv_rem_r[i+1]  <= rem_nxt;
        dv_quo_r[i+1]  <= quo_nxt;
      end
    end
  end

  // Output register: pick the values by mode and pack the beat.
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0]   out_user_r;
  meta_t                   mo;
  logic signed [3:0][31:0] val;

  always_comb begin
    mo  = dv_meta_r[DIV_STEPS];
    val = '0;
    if (mo.anim) begin
      case (mo.kind)
        MODE_ROTATION: begin
          if (!mo.tiny_len) begin
            for (int j = 0; j < 4; j++)
              val[j] = dv_mneg_r[DIV_STEPS][j] ? -32'(dv_quo_r[DIV_STEPS][j])
                                                :  32'(dv_quo_r[DIV_STEPS][j]);
          end
        end
        MODE_TRANSLATE, MODE_SCALE: val[0] = mo.val0;
        default: ;
      endcase
    end
    out_data_nxt = {5'b0, val[3], val[2], val[1], val[0], mo.a, mo.k, mo.slot};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_vld_r[DIV_STEPS];
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= {mo.anim, mo.kind};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
